FILE: sv/tfc_pkg.sv
// Shared types, constants and tables of the thermal frame classifier.
package tfc_pkg;

    localparam int FRAME_SIDE = 8;
    localparam int LEVELS     = 10;

    localparam int TEMP_W  = 12;
    localparam int SIDE_W  = (FRAME_SIDE > 1) ? $clog2(FRAME_SIDE) : 1;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int NUM_W   = TEMP_W + LVL_W;
    localparam int STEP_W  = (LVL_W > 1) ? $clog2(LVL_W) : 1;
    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORANGE_LIMIT = 3'd5;

    localparam logic signed [TEMP_W-1:0] RST_DISPLAY_LOW  = 12'sd88;
    localparam logic signed [TEMP_W-1:0] RST_DISPLAY_HIGH = 12'sd128;
    localparam logic signed [TEMP_W-1:0] RST_BLUE_LIMIT   = 12'sd80;
    localparam logic signed [TEMP_W-1:0] RST_GREEN_LIMIT  = 12'sd96;
    localparam logic signed [TEMP_W-1:0] RST_YELLOW_LIMIT = 12'sd112;
    localparam logic signed [TEMP_W-1:0] RST_ORANGE_LIMIT = 12'sd128;

    localparam logic signed [TEMP_W-1:0] MIN_SENTINEL = 12'sd800;
    localparam logic signed [TEMP_W-1:0] MAX_SENTINEL = -12'sd400;

    localparam logic [15:0] COL_BLUE   = 16'h001F;
    localparam logic [15:0] COL_GREEN  = 16'h07E0;
    localparam logic [15:0] COL_YELLOW = 16'hFFE0;
    localparam logic [15:0] COL_ORANGE = 16'hF860;
    localparam logic [15:0] COL_RED    = 16'hF800;

    // first character sits in the top byte
    localparam logic [9:0][7:0] SYM_CHARS = " .:-=+*#%@";

    typedef logic [2**LVL_W-1:0][6:0] sym_table_t;

    function automatic sym_table_t build_sym_table();
        sym_table_t tbl;
        int idx;
        for (int i = 0; i < 2**LVL_W; i++) begin
            idx = (i * 9) / (LEVELS - 1);
            if (idx > 9) begin
                idx = 9;
            end
            tbl[i] = SYM_CHARS[9 - idx][6:0];
        end
        return tbl;
    endfunction

    localparam sym_table_t LEVEL_SYM = build_sym_table();

    typedef struct packed {
        logic signed [TEMP_W-1:0] display_low;
        logic signed [TEMP_W-1:0] display_high;
        logic signed [TEMP_W-1:0] blue_limit;
        logic signed [TEMP_W-1:0] green_limit;
        logic signed [TEMP_W-1:0] yellow_limit;
        logic signed [TEMP_W-1:0] orange_limit;
    } tfc_cfg_t;

    // one classified pixel waiting for the back end (level division if inside the window)
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     in_window;
        logic [LVL_W-1:0]         edge_level;
        logic [NUM_W-1:0]         num;
        logic [TEMP_W-1:0]        den;
        logic [15:0]              colour;
        logic                     done;
        logic signed [TEMP_W-1:0] fmin;
        logic signed [TEMP_W-1:0] fmax;
        logic [2:0]               hot_row;
        logic [2:0]               hot_col;
    } tfc_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } tfc_back_state_t;

endpackage

FILE: sv/thermal_frame_classifier.sv
// Thermal frame classifier top level: configuration registers and block wiring.
// A word inside the display window goes through the 4-step level divider (BK_DIV)
// before it is shown in BK_OUT; a word at or beyond a window edge goes to BK_OUT.
// Throughput: inside the window the divider takes no new word until its division
// ends, one quotient bit a cycle; otherwise one word per cycle while out_stall is
// low; a 2-deep queue feeds it. Reset (rst_n, asynchronous): thresholds to
// defaults, statistics to sentinels, queue empty and output not valid.
module thermal_frame_classifier
    import tfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [TEMP_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [15:0]              raw_pixel,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temp_quarter,
    output logic [3:0]               level_index,
    output logic [6:0]               level_symbol,
    output logic [15:0]              colour_rgb565,
    output logic                     frame_done,
    output logic signed [TEMP_W-1:0] frame_min,
    output logic signed [TEMP_W-1:0] frame_max,
    output logic [2:0]               hot_row,
    output logic [2:0]               hot_col
);

    tfc_cfg_t cfg_reg, cfg_next;
    tfc_job_t push_job;
    tfc_job_t head_job;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_DISPLAY_LOW:  cfg_next.display_low  = signed'(cfg_data);
                CFG_DISPLAY_HIGH: cfg_next.display_high = signed'(cfg_data);
                CFG_BLUE_LIMIT:   cfg_next.blue_limit   = signed'(cfg_data);
                CFG_GREEN_LIMIT:  cfg_next.green_limit  = signed'(cfg_data);
                CFG_YELLOW_LIMIT: cfg_next.yellow_limit = signed'(cfg_data);
                CFG_ORANGE_LIMIT: cfg_next.orange_limit = signed'(cfg_data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.display_low  <= RST_DISPLAY_LOW;
            cfg_reg.display_high <= RST_DISPLAY_HIGH;
            cfg_reg.blue_limit   <= RST_BLUE_LIMIT;
            cfg_reg.green_limit  <= RST_GREEN_LIMIT;
            cfg_reg.yellow_limit <= RST_YELLOW_LIMIT;
            cfg_reg.orange_limit <= RST_ORANGE_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_pixel (raw_pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    tfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    tfc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .temp_quarter  (temp_quarter),
        .level_index   (level_index),
        .level_symbol  (level_symbol),
        .colour_rgb565 (colour_rgb565),
        .frame_done    (frame_done),
        .frame_min     (frame_min),
        .frame_max     (frame_max),
        .hot_row       (hot_row),
        .hot_col       (hot_col)
    );

endmodule

FILE: sv/tfc_front.sv
// Front end: takes pixel words, classifies them and keeps the frame statistics.
module tfc_front
    import tfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tfc_cfg_t          cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       raw_pixel,
    input  logic              q_full,
    output logic              q_push,
    output tfc_job_t          q_job
);

    logic signed [TEMP_W-1:0] min_reg, min_next;
    logic signed [TEMP_W-1:0] max_reg, max_next;
    logic [SIDE_W-1:0]        row_reg, row_next;
    logic [SIDE_W-1:0]        col_reg, col_next;
    logic [SIDE_W-1:0]        hot_row_reg, hot_row_next;
    logic [SIDE_W-1:0]        hot_col_reg, hot_col_next;

    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W:0]   diff;
    logic signed [TEMP_W:0]   span;
    logic                     at_low;
    logic                     at_high;
    logic                     last_pix;
    logic                     new_max;
    logic [15:0]              colour;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // upper nibble of the word is ignored
    assign temp    = signed'(raw_pixel[TEMP_W-1:0]);
    assign at_low  = temp <= cfg.display_low;
    assign at_high = temp >= cfg.display_high;
    assign diff    = (TEMP_W+1)'(temp) - (TEMP_W+1)'(cfg.display_low);
    assign span    = (TEMP_W+1)'(cfg.display_high) - (TEMP_W+1)'(cfg.display_low);

    assign last_pix = (row_reg == SIDE_W'(FRAME_SIDE - 1)) &&
                      (col_reg == SIDE_W'(FRAME_SIDE - 1));
    assign new_max  = temp > max_reg;

    always_comb
    begin
        if (temp < cfg.blue_limit) begin
            colour = COL_BLUE;
        end else if (temp < cfg.green_limit) begin
            colour = COL_GREEN;
        end else if (temp < cfg.yellow_limit) begin
            colour = COL_YELLOW;
        end else if (temp < cfg.orange_limit) begin
            colour = COL_ORANGE;
        end else begin
            colour = COL_RED;
        end
    end

    always_comb
    begin
        max_next     = new_max ? temp : max_reg;
        min_next     = (temp < min_reg) ? temp : min_reg;
        hot_row_next = new_max ? row_reg : hot_row_reg;
        hot_col_next = new_max ? col_reg : hot_col_reg;

        if (col_reg == SIDE_W'(FRAME_SIDE - 1)) begin
            col_next = '0;
            row_next = row_reg + SIDE_W'(1);
        end else begin
            col_next = col_reg + SIDE_W'(1);
            row_next = row_reg;
        end

        q_job            = '0;
        q_job.temp       = temp;
        q_job.in_window  = !at_low && !at_high;
        q_job.edge_level = at_low ? '0 : LVL_W'(LEVELS - 1);
        q_job.num        = NUM_W'(diff[TEMP_W-1:0]) * NUM_W'(LEVELS);
        q_job.den        = span[TEMP_W-1:0];
        q_job.colour     = colour;
        q_job.done       = last_pix;
        if (last_pix) begin
            q_job.fmin    = min_next;
            q_job.fmax    = max_next;
            q_job.hot_row = 3'(hot_row_next);
            q_job.hot_col = 3'(hot_col_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_reg     <= MIN_SENTINEL;
            max_reg     <= MAX_SENTINEL;
            row_reg     <= '0;
            col_reg     <= '0;
            hot_row_reg <= '0;
            hot_col_reg <= '0;
        end else if (q_push) begin
            if (last_pix) begin
                min_reg     <= MIN_SENTINEL;
                max_reg     <= MAX_SENTINEL;
                row_reg     <= '0;
                col_reg     <= '0;
                hot_row_reg <= '0;
                hot_col_reg <= '0;
            end else begin
                min_reg     <= min_next;
                max_reg     <= max_next;
                row_reg     <= row_next;
                col_reg     <= col_next;
                hot_row_reg <= hot_row_next;
                hot_col_reg <= hot_col_next;
            end
        end
    end

endmodule

FILE: sv/tfc_queue.sv
// Short job queue between the front end and the level divider.
module tfc_queue
    import tfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  tfc_job_t push_job,
    output logic     full,
    input  logic     pop,
    output tfc_job_t head_job,
    output logic     empty
);

    tfc_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/tfc_back.sv
// Back end: restoring divider for the gradient level and the result register.
module tfc_back
    import tfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tfc_job_t                 head_job,
    input  logic                     q_empty,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temp_quarter,
    output logic [3:0]               level_index,
    output logic [6:0]               level_symbol,
    output logic [15:0]              colour_rgb565,
    output logic                     frame_done,
    output logic signed [TEMP_W-1:0] frame_min,
    output logic signed [TEMP_W-1:0] frame_max,
    output logic [2:0]               hot_row,
    output logic [2:0]               hot_col
);

    tfc_back_state_t state_reg, state_next;

    tfc_job_t          job_reg;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsr_reg;
    logic [LVL_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [6:0]        sym_reg;
    logic              fits;
    logic              div_end;

    // one quotient bit per cycle, msb first
    assign fits     = rem_reg >= dsr_reg;
    assign rem_next = fits ? rem_reg - dsr_reg : rem_reg;
    assign quo_next = (quo_reg << 1) | LVL_W'(fits);
    assign div_end  = (state_reg == BK_DIV) && (step_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = head_job.in_window ? BK_DIV : BK_OUT;
                end
            end
            BK_DIV:
            begin
                if (step_reg == '0) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall) begin
                    if (!q_empty) begin
                        q_pop      = 1'b1;
                        state_next = head_job.in_window ? BK_DIV : BK_OUT;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            job_reg  <= head_job;
            rem_reg  <= head_job.num;
            dsr_reg  <= NUM_W'(head_job.den) << (LVL_W - 1);
            quo_reg  <= '0;
            step_reg <= STEP_W'(LVL_W - 1);
            if (!head_job.in_window) begin
                level_reg <= head_job.edge_level;
                sym_reg   <= LEVEL_SYM[head_job.edge_level];
            end
        end else if (state_reg == BK_DIV) begin
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_reg >> 1;
            quo_reg  <= quo_next;
            step_reg <= step_reg - STEP_W'(1);
            if (div_end) begin
                level_reg <= quo_next;
                sym_reg   <= LEVEL_SYM[quo_next];
            end
        end
    end

    assign temp_quarter  = job_reg.temp;
    assign level_index   = 4'(level_reg);
    assign level_symbol  = sym_reg;
    assign colour_rgb565 = job_reg.colour;
    assign frame_done    = job_reg.done;
    assign frame_min     = job_reg.fmin;
    assign frame_max     = job_reg.fmax;
    assign hot_row       = job_reg.hot_row;
    assign hot_col       = job_reg.hot_col;

endmodule
